FILE: rtl/core/dol_pkg.sv
// ----------------------------------------------------------------------------
// dol_pkg
// Types and constants shared by the draw-order entry list controller and
// datapath.
// ----------------------------------------------------------------------------
package dol_pkg;

  localparam int ID_W        = 6;
  localparam int COORD_W     = 8;
  localparam int MAX_RESULTS = 64;
  localparam int RES_CNT_W   = 6;

  typedef enum logic [1:0] {
    ACT_INSERT  = 2'd0,
    ACT_REMOVE  = 2'd1,
    ACT_SET_VIS = 2'd2,
    ACT_LIST    = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_FULL      = 2'd2,
    ST_EMPTY     = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    SEL_ERR     = 3'd0,
    SEL_INSERT  = 3'd1,
    SEL_REMOVE  = 3'd2,
    SEL_SET_VIS = 3'd3,
    SEL_LIST    = 3'd4
  } out_sel_t;

  typedef struct packed {
    logic     load;
    logic     scan_clr;
    logic     slot_inc;
    logic     id_inc;
    logic     ins_write;
    logic     take_id;
    logic     head_init;
    logic     rd_head;
    logic     rd_next;
    logic     append;
    logic     link1;
    logic     link2;
    logic     unlink;
    logic     set_vis;
    logic     list_inc;
    logic     out_load;
    out_sel_t out_sel;
    status_t  out_status;
  } dol_cmd_t;

  typedef struct packed {
    action_t action;
    logic    auto_id;
    logic    head_null;
    logic    slot_free;
    logic    slot_end;
    logic    id_free;
    logic    id_end;
    logic    front;
    logic    after;
    logic    id_match;
    logic    next_null;
    logic    list_end;
    logic    out_free;
  } dol_stat_t;

endpackage

FILE: rtl/core/dol_ctrl.sv
// ----------------------------------------------------------------------------
// dol_ctrl
// Sequencer for the entry list: scans, walks, links and emits results.
// ----------------------------------------------------------------------------
module dol_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  input  dol_pkg::dol_stat_t stat,
  output dol_pkg::dol_cmd_t  cmd,
  output logic             idle
);
  import dol_pkg::*;

  typedef enum logic [9:0] {
    S_IDLE      = 10'b0000000001,
    S_START     = 10'b0000000010,
    S_SCAN_SLOT = 10'b0000000100,
    S_SCAN_ID   = 10'b0000001000,
    S_INS_WRITE = 10'b0000010000,
    S_WALK      = 10'b0000100000,
    S_LINK1     = 10'b0001000000,
    S_LINK2     = 10'b0010000000,
    S_EMIT      = 10'b0100000000,
    S_LIST      = 10'b1000000000
  } state_t;

  state_t   state, state_next;
  out_sel_t emit_sel, emit_sel_next;
  status_t  emit_status, emit_status_next;
  logic     append, append_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
    emit_sel    <= emit_sel_next;
    emit_status <= emit_status_next;
    append      <= append_next;
  end

  always_comb begin
    cmd              = '0;
    cmd.out_sel      = SEL_ERR;
    cmd.out_status   = ST_OK;
    cmd.append       = append;
    state_next       = state;
    emit_sel_next    = emit_sel;
    emit_status_next = emit_status;
    append_next      = append;
    idle             = 1'b0;
    unique case (state)
      S_IDLE: begin
        idle = 1'b1;
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_START;
        end
      end
      S_START: begin
        cmd.scan_clr = 1'b1;
        if (stat.action == ACT_INSERT) begin
          state_next = S_SCAN_SLOT;
        end else if (stat.head_null) begin
          emit_sel_next    = SEL_ERR;
          emit_status_next = ST_EMPTY;
          state_next       = S_EMIT;
        end else begin
          cmd.rd_head = 1'b1;
          state_next  = (stat.action == ACT_LIST) ? S_LIST : S_WALK;
        end
      end
      S_SCAN_SLOT: begin
        if (stat.slot_free) begin
          state_next = stat.auto_id ? S_SCAN_ID : S_INS_WRITE;
        end else if (stat.slot_end) begin
          emit_sel_next    = SEL_ERR;
          emit_status_next = ST_FULL;
          state_next       = S_EMIT;
        end else begin
          cmd.slot_inc = 1'b1;
        end
      end
      S_SCAN_ID: begin
        if (stat.id_free) begin
          state_next = S_INS_WRITE;
        end else if (stat.id_end) begin
          emit_sel_next    = SEL_ERR;
          emit_status_next = ST_FULL;
          state_next       = S_EMIT;
        end else begin
          cmd.id_inc = 1'b1;
        end
      end
      S_INS_WRITE: begin
        cmd.ins_write = 1'b1;
        cmd.take_id   = stat.auto_id;
        if (stat.head_null) begin
          cmd.head_init    = 1'b1;
          emit_sel_next    = SEL_INSERT;
          emit_status_next = ST_OK;
          state_next       = S_EMIT;
        end else begin
          cmd.rd_head = 1'b1;
          state_next  = S_WALK;
        end
      end
      S_WALK: begin
        if (stat.action == ACT_INSERT) begin
          if (stat.front || !stat.after) begin
            append_next = 1'b0;
            state_next  = S_LINK1;
          end else if (stat.next_null) begin
            append_next = 1'b1;
            state_next  = S_LINK1;
          end else begin
            cmd.rd_next = 1'b1;
          end
        end else if (stat.id_match) begin
          emit_status_next = ST_OK;
          if (stat.action == ACT_REMOVE) begin
            cmd.unlink    = 1'b1;
            emit_sel_next = SEL_REMOVE;
          end else begin
            cmd.set_vis   = 1'b1;
            emit_sel_next = SEL_SET_VIS;
          end
          state_next = S_EMIT;
        end else if (stat.next_null) begin
          emit_sel_next    = SEL_ERR;
          emit_status_next = ST_NOT_FOUND;
          state_next       = S_EMIT;
        end else begin
          cmd.rd_next = 1'b1;
        end
      end
      S_LINK1: begin
        cmd.link1  = 1'b1;
        state_next = S_LINK2;
      end
      S_LINK2: begin
        cmd.link2        = 1'b1;
        emit_sel_next    = SEL_INSERT;
        emit_status_next = ST_OK;
        state_next       = S_EMIT;
      end
      S_EMIT: begin
        if (stat.out_free) begin
          cmd.out_load   = 1'b1;
          cmd.out_sel    = emit_sel;
          cmd.out_status = emit_status;
          state_next     = S_IDLE;
        end
      end
      S_LIST: begin
        if (stat.out_free) begin
          cmd.out_load   = 1'b1;
          cmd.out_sel    = SEL_LIST;
          cmd.out_status = ST_OK;
          if (stat.list_end) begin
            state_next = S_IDLE;
          end else begin
            cmd.rd_next  = 1'b1;
            cmd.list_inc = 1'b1;
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

FILE: rtl/core/dol_datapath.sv
// ----------------------------------------------------------------------------
// dol_datapath
// Entry memories, occupancy and id maps, link updates and the result register.
// ----------------------------------------------------------------------------
module dol_datapath #(
  parameter int POOL_SLOTS = 64,
  parameter int ID_COUNT   = 64
) (
  input  logic                        clk,
  input  logic                        rst,
  input  dol_pkg::dol_cmd_t           cmd,
  output dol_pkg::dol_stat_t          stat,
  input  logic [1:0]                  action,
  input  logic [5:0]                  entry_id,
  input  logic                        auto_id,
  input  logic signed [7:0]           pos_x,
  input  logic signed [7:0]           pos_y,
  input  logic signed [7:0]           pos_z,
  input  logic                        keep_id,
  input  logic                        visible,
  input  logic                        out_stall,
  output logic                        out_valid,
  output logic [1:0]                  status,
  output logic [5:0]                  result_id,
  output logic                        result_visible,
  output logic                        last
);
  import dol_pkg::*;

  localparam int SW       = $clog2(POOL_SLOTS);
  localparam int LW       = SW + 1;
  localparam int TW       = $clog2(ID_COUNT);
  localparam int ID_LIMIT = (ID_COUNT < 64) ? ID_COUNT : 64;
  localparam logic [LW-1:0] LINK_NULL = {1'b1, {SW{1'b0}}};

  // Latched request
  action_t                    action_q;
  logic [ID_W-1:0]            id_q;
  logic                       auto_q, keep_q, vis_q;
  logic signed [COORD_W-1:0]  x_q, y_q, z_q;

  // Entry memories
  logic [ID_W-1:0]            mem_id    [POOL_SLOTS];
  logic signed [COORD_W-1:0]  mem_x     [POOL_SLOTS];
  logic signed [COORD_W-1:0]  mem_y     [POOL_SLOTS];
  logic signed [COORD_W-1:0]  mem_z     [POOL_SLOTS];
  logic                       mem_shown [POOL_SLOTS];
  logic [LW-1:0]              mem_next  [POOL_SLOTS];
  logic [LW-1:0]              mem_prev  [POOL_SLOTS];

  logic [ID_W-1:0]            id_rd;
  logic signed [COORD_W-1:0]  x_rd, y_rd, z_rd;
  logic                       shown_rd;
  logic [LW-1:0]              next_rd, prev_rd;
  logic [SW-1:0]              rd_slot, rd_addr;
  logic                       rd_en;

  logic [POOL_SLOTS-1:0]      used;
  logic [ID_COUNT-1:0]        taken;
  logic [LW-1:0]              head;
  logic [SW-1:0]              slot_cnt;
  logic [ID_W-1:0]            id_cnt;
  logic [RES_CNT_W-1:0]       list_cnt;

  logic [7:0]                 id_scan_ext, id_q_ext;
  logic [ID_W-1:0]            ins_id;
  logic [LW-1:0]              s_link, p_link;

  logic                       next_we, prev_we, shown_we, head_we;
  logic [SW-1:0]              next_wa, prev_wa, shown_wa;
  logic [LW-1:0]              next_wd, prev_wd, head_wd;
  logic                       shown_wd;
  logic                       out_free;

  assign id_scan_ext = {2'b00, id_cnt};
  assign id_q_ext    = {2'b00, id_q};
  assign ins_id      = auto_q ? id_cnt : id_q;
  assign s_link      = {1'b0, slot_cnt};
  assign p_link      = {1'b0, rd_slot};
  assign rd_en       = cmd.rd_head | cmd.rd_next;
  assign rd_addr     = cmd.rd_head ? head[SW-1:0] : next_rd[SW-1:0];
  assign out_free    = !out_valid || !out_stall;

  always_comb begin
    stat.action    = action_q;
    stat.auto_id   = auto_q;
    stat.head_null = head[SW];
    stat.slot_free = !used[slot_cnt];
    stat.slot_end  = (slot_cnt == SW'(POOL_SLOTS - 1));
    stat.id_free   = !taken[id_scan_ext[TW-1:0]];
    stat.id_end    = (id_cnt == ID_W'(ID_LIMIT - 1));
    stat.front     = (z_q == -8'sd1);
    if (x_rd != x_q) begin
      stat.after = x_rd < x_q;
    end else if (y_rd != y_q) begin
      stat.after = y_rd > y_q;
    end else begin
      stat.after = z_rd <= z_q;
    end
    stat.id_match  = (id_rd == id_q);
    stat.next_null = next_rd[SW];
    stat.list_end  = next_rd[SW] || (list_cnt == RES_CNT_W'(MAX_RESULTS - 1));
    stat.out_free  = out_free;
  end

  // Link write ports: one write per memory per cycle.
  always_comb begin
    next_we  = 1'b0;
    next_wa  = slot_cnt;
    next_wd  = LINK_NULL;
    prev_we  = 1'b0;
    prev_wa  = slot_cnt;
    prev_wd  = LINK_NULL;
    head_we  = 1'b0;
    head_wd  = s_link;
    shown_we = 1'b0;
    shown_wa = slot_cnt;
    shown_wd = vis_q;
    if (cmd.ins_write) begin
      shown_we = 1'b1;
    end
    if (cmd.set_vis) begin
      shown_we = 1'b1;
      shown_wa = rd_slot;
    end
    if (cmd.head_init) begin
      next_we = 1'b1;
      prev_we = 1'b1;
      head_we = 1'b1;
    end
    if (cmd.link1) begin
      prev_we = 1'b1;
      if (cmd.append) begin
        next_we = 1'b1;
        next_wa = rd_slot;
        next_wd = s_link;
        prev_wd = p_link;
      end else begin
        prev_wd = prev_rd;
        if (prev_rd[SW]) begin
          head_we = 1'b1;
        end else begin
          next_we = 1'b1;
          next_wa = prev_rd[SW-1:0];
          next_wd = s_link;
        end
      end
    end
    if (cmd.link2) begin
      next_we = 1'b1;
      if (!cmd.append) begin
        next_wd = p_link;
        prev_we = 1'b1;
        prev_wa = rd_slot;
        prev_wd = s_link;
      end
    end
    if (cmd.unlink) begin
      if (prev_rd[SW]) begin
        head_we = 1'b1;
        head_wd = next_rd;
      end else begin
        next_we = 1'b1;
        next_wa = prev_rd[SW-1:0];
        next_wd = next_rd;
      end
      if (!next_rd[SW]) begin
        prev_we = 1'b1;
        prev_wa = next_rd[SW-1:0];
        prev_wd = prev_rd;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.ins_write) begin
      mem_id[slot_cnt] <= ins_id;
      mem_x[slot_cnt]  <= x_q;
      mem_y[slot_cnt]  <= y_q;
      mem_z[slot_cnt]  <= z_q;
    end
    if (shown_we) begin
      mem_shown[shown_wa] <= shown_wd;
    end
    if (next_we) begin
      mem_next[next_wa] <= next_wd;
    end
    if (prev_we) begin
      mem_prev[prev_wa] <= prev_wd;
    end
    if (rd_en) begin
      id_rd    <= mem_id[rd_addr];
      x_rd     <= mem_x[rd_addr];
      y_rd     <= mem_y[rd_addr];
      z_rd     <= mem_z[rd_addr];
      shown_rd <= mem_shown[rd_addr];
      next_rd  <= mem_next[rd_addr];
      prev_rd  <= mem_prev[rd_addr];
      rd_slot  <= rd_addr;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      used  <= '0;
      taken <= '0;
      head  <= LINK_NULL;
    end else begin
      if (cmd.ins_write) begin
        used[slot_cnt] <= 1'b1;
      end
      if (cmd.take_id) begin
        taken[id_scan_ext[TW-1:0]] <= 1'b1;
      end
      if (cmd.unlink) begin
        used[rd_slot] <= 1'b0;
        if (!keep_q && (id_q_ext < 8'(ID_COUNT))) begin
          taken[id_q_ext[TW-1:0]] <= 1'b0;
        end
      end
      if (head_we) begin
        head <= head_wd;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      action_q <= action_t'(action);
      id_q     <= entry_id;
      auto_q   <= auto_id;
      x_q      <= pos_x;
      y_q      <= pos_y;
      z_q      <= pos_z;
      keep_q   <= keep_id;
      vis_q    <= visible;
    end
    if (cmd.scan_clr) begin
      slot_cnt <= '0;
      id_cnt   <= '0;
      list_cnt <= '0;
    end else begin
      if (cmd.slot_inc) begin
        slot_cnt <= slot_cnt + 1'b1;
      end
      if (cmd.id_inc) begin
        id_cnt <= id_cnt + 1'b1;
      end
      if (cmd.list_inc) begin
        list_cnt <= list_cnt + 1'b1;
      end
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      status <= cmd.out_status;
      unique case (cmd.out_sel)
        SEL_INSERT: begin
          result_id      <= ins_id;
          result_visible <= vis_q;
          last           <= 1'b1;
        end
        SEL_REMOVE: begin
          result_id      <= id_q;
          result_visible <= shown_rd;
          last           <= 1'b1;
        end
        SEL_SET_VIS: begin
          result_id      <= id_q;
          result_visible <= vis_q;
          last           <= 1'b1;
        end
        SEL_LIST: begin
          result_id      <= id_rd;
          result_visible <= shown_rd;
          last           <= stat.list_end;
        end
        default: begin
          result_id      <= '0;
          result_visible <= 1'b0;
          last           <= 1'b1;
        end
      endcase
    end
  end

  // A non-empty list always starts at an occupied slot.
  a_head_used: assert property (@(posedge clk) disable iff (rst)
    !head[SW] |-> used[head[SW-1:0]])
    else $error("list head points at a free slot");

  // A new entry only ever lands in a free slot.
  a_ins_free: assert property (@(posedge clk) disable iff (rst)
    cmd.ins_write |-> !used[slot_cnt])
    else $error("insert overwrites an occupied slot");

  // The written slot is marked occupied on the following cycle.
  a_ins_marks: assert property (@(posedge clk) disable iff (rst)
    cmd.ins_write |=> used[$past(slot_cnt)])
    else $error("inserted slot not marked occupied");

endmodule

FILE: rtl/core/depth_ordered_entry_list.sv
// ----------------------------------------------------------------------------
// depth_ordered_entry_list
// Pool of entries kept linked in draw order, with insert, remove, visibility
// update and in-order listing of entry ids.
// ----------------------------------------------------------------------------
// Insert scans up to POOL_SLOTS slots for a free one and, with auto id, up
// to ID_COUNT ids (at most 64) for a free id, writes the entry, walks the
// list to its place, links it in and emits; into an empty list it is written
// as the head. Remove and set visibility walk the list to the matching id;
// list emits one result per entry. One request is handled at a time, the walk
// reading one slot per cycle. Synchronous reset clears occupancy, ids, head.
module depth_ordered_entry_list #(
  parameter int POOL_SLOTS = 64,
  parameter int ID_COUNT   = 64
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [1:0]        action,
  input  logic [5:0]        entry_id,
  input  logic              auto_id,
  input  logic signed [7:0] pos_x,
  input  logic signed [7:0] pos_y,
  input  logic signed [7:0] pos_z,
  input  logic              keep_id,
  input  logic              visible,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [1:0]        status,
  output logic [5:0]        result_id,
  output logic              result_visible,
  output logic              last
);
  import dol_pkg::*;

  // The controller sequences scans, list walks and link updates; the
  // datapath holds the entry memories and the result register.
  dol_cmd_t  cmd;
  dol_stat_t stat;
  logic      idle;

  // A new request is taken only when the sequencer is idle; the result
  // register lets the last result wait while the next request is taken.
  assign in_stall = !idle;

  dol_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .stat     (stat),
    .cmd      (cmd),
    .idle     (idle)
  );

  dol_datapath #(
    .POOL_SLOTS (POOL_SLOTS),
    .ID_COUNT   (ID_COUNT)
  ) u_datapath (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .stat           (stat),
    .action         (action),
    .entry_id       (entry_id),
    .auto_id        (auto_id),
    .pos_x          (pos_x),
    .pos_y          (pos_y),
    .pos_z          (pos_z),
    .keep_id        (keep_id),
    .visible        (visible),
    .out_stall      (out_stall),
    .out_valid      (out_valid),
    .status         (status),
    .result_id      (result_id),
    .result_visible (result_visible),
    .last           (last)
  );

endmodule

FILE: sim/depth_ordered_entry_list_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// depth_ordered_entry_list_checker
// Watches both channels of the draw-order entry list, keeps its own copy of
// the pool and id map, predicts every result and compares it in order.
// ----------------------------------------------------------------------------
module depth_ordered_entry_list_checker (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  logic              in_stall,
  input  logic [1:0]        action,
  input  logic [5:0]        entry_id,
  input  logic              auto_id,
  input  logic signed [7:0] pos_x,
  input  logic signed [7:0] pos_y,
  input  logic signed [7:0] pos_z,
  input  logic              keep_id,
  input  logic              visible,
  input  logic              out_valid,
  input  logic              out_stall,
  input  logic [1:0]        status,
  input  logic [5:0]        result_id,
  input  logic              result_visible,
  input  logic              last,
  output int                fail_count,
  output int                pending_count,
  output int                result_count
);
  import dol_pkg::*;

  localparam int SLOTS = 64;
  localparam int NONE  = SLOTS;

  typedef struct packed {
    status_t    st;
    logic [5:0] id;
    logic       vis;
    logic       fin;
  } list_result_t;

  list_result_t due_results[$];

  logic              used_q [SLOTS];
  logic [5:0]        eid_q  [SLOTS];
  logic signed [7:0] ex_q   [SLOTS];
  logic signed [7:0] ey_q   [SLOTS];
  logic signed [7:0] ez_q   [SLOTS];
  logic              shown_q[SLOTS];
  int                nxt_q  [SLOTS];
  int                prv_q  [SLOTS];
  int                head_q;
  logic [63:0]       taken_q;

  function automatic list_result_t mk(status_t s, logic [5:0] i, logic v, logic f);
    list_result_t r;
    r.st = s; r.id = i; r.vis = v; r.fin = f;
    return r;
  endfunction

  function automatic int locate_id(logic [5:0] id);
    int p;
    p = head_q;
    for (int n = 0; n < SLOTS && p < SLOTS; n++) begin
      if (eid_q[p] == id) return p;
      p = nxt_q[p];
    end
    return NONE;
  endfunction

  function automatic bit passes(int p, logic signed [7:0] x, logic signed [7:0] y,
                                logic signed [7:0] z);
    if (ex_q[p] != x) return ex_q[p] < x;
    if (ey_q[p] != y) return ey_q[p] > y;
    return ez_q[p] <= z;
  endfunction

  function automatic void link_ahead(int s, int p);
    prv_q[s] = prv_q[p];
    if (prv_q[p] < SLOTS) nxt_q[prv_q[p]] = s;
    else head_q = s;
    prv_q[p] = s;
    nxt_q[s] = p;
  endfunction

  // Applies one accepted request to the shadow pool and queues its results.
  task automatic predict_request();
    int s, i, p, k;
    logic [5:0] id;
    s = 0; i = 0; p = 0; k = 0; id = '0;
    case (action_t'(action))
      ACT_INSERT: begin
        while (s < SLOTS && used_q[s]) s++;
        if (s >= SLOTS) begin
          due_results.push_back(mk(ST_FULL, '0, 1'b0, 1'b1));
          return;
        end
        if (auto_id) begin
          while (i < 64 && taken_q[i]) i++;
          if (i >= 64) begin
            due_results.push_back(mk(ST_FULL, '0, 1'b0, 1'b1));
            return;
          end
          taken_q[i] = 1'b1;
          id = i[5:0];
        end else id = entry_id;
        used_q[s] = 1'b1; eid_q[s] = id; ex_q[s] = pos_x; ey_q[s] = pos_y;
        ez_q[s] = pos_z; shown_q[s] = visible;
        if (head_q >= SLOTS) begin
          head_q = s; prv_q[s] = NONE; nxt_q[s] = NONE;
        end else if (pos_z == -8'sd1) begin
          link_ahead(s, head_q);
        end else begin
          p = head_q;
          for (int n = 0; n < SLOTS; n++) begin
            if (!passes(p, pos_x, pos_y, pos_z)) begin
              link_ahead(s, p);
              break;
            end
            if (nxt_q[p] >= SLOTS) begin
              nxt_q[p] = s; prv_q[s] = p; nxt_q[s] = NONE;
              break;
            end
            p = nxt_q[p];
          end
        end
        due_results.push_back(mk(ST_OK, id, visible, 1'b1));
      end
      ACT_REMOVE, ACT_SET_VIS: begin
        if (head_q >= SLOTS) begin
          due_results.push_back(mk(ST_EMPTY, '0, 1'b0, 1'b1));
          return;
        end
        p = locate_id(entry_id);
        if (p >= SLOTS) begin
          due_results.push_back(mk(ST_NOT_FOUND, '0, 1'b0, 1'b1));
          return;
        end
        if (action_t'(action) == ACT_SET_VIS) begin
          shown_q[p] = visible;
        end else begin
          if (!keep_id) taken_q[entry_id] = 1'b0;
          if (prv_q[p] < SLOTS) nxt_q[prv_q[p]] = nxt_q[p];
          else head_q = nxt_q[p];
          if (nxt_q[p] < SLOTS) prv_q[nxt_q[p]] = prv_q[p];
          used_q[p] = 1'b0;
        end
        due_results.push_back(mk(ST_OK, entry_id, shown_q[p], 1'b1));
      end
      default: begin
        p = head_q;
        if (p >= SLOTS) begin
          due_results.push_back(mk(ST_EMPTY, '0, 1'b0, 1'b1));
          return;
        end
        while (k < MAX_RESULTS && p < SLOTS) begin
          due_results.push_back(mk(ST_OK, eid_q[p], shown_q[p], 1'b0));
          k++;
          p = nxt_q[p];
        end
        due_results[$].fin = 1'b1;
      end
    endcase
  endtask

  always @(posedge clk) begin
    list_result_t want;
    if (rst) begin
      for (int n = 0; n < SLOTS; n++) begin
        used_q[n] = 1'b0; nxt_q[n] = NONE; prv_q[n] = NONE;
      end
      head_q = NONE;
      taken_q = '0;
      due_results.delete();
      fail_count <= 0;
      result_count <= 0;
      pending_count <= 0;
    end else begin
      if (out_valid && !out_stall) begin
        result_count <= result_count + 1;
        if (due_results.size() == 0) begin
          $error("unexpected result: status %0d id %0d", status, result_id);
          fail_count <= fail_count + 1;
        end else begin
          want = due_results.pop_front();
          if (status !== want.st) begin
            $error("status: expected %0d, got %0d", want.st, status);
            fail_count <= fail_count + 1;
          end
          if (result_id !== want.id) begin
            $error("result_id: expected %0d, got %0d", want.id, result_id);
            fail_count <= fail_count + 1;
          end
          if (result_visible !== want.vis) begin
            $error("result_visible: expected %0d, got %0d", want.vis, result_visible);
            fail_count <= fail_count + 1;
          end
          if (last !== want.fin) begin
            $error("last: expected %0d, got %0d", want.fin, last);
            fail_count <= fail_count + 1;
          end
        end
      end
      if (in_valid && !in_stall) predict_request();
      pending_count <= due_results.size();
    end
  end

endmodule

FILE: sim/depth_ordered_entry_list_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// depth_ordered_entry_list_tb
// Drives directed and random insert, remove, visibility and list requests
// into the draw-order entry list, with random gaps and stalls, and reports
// the checker's verdict.
// ----------------------------------------------------------------------------
module depth_ordered_entry_list_tb;
  import dol_pkg::*;

  localparam int RANDOM_REQUESTS = 200;
  localparam int CYCLE_LIMIT     = 3000000;
  localparam int HOLD_CYCLES     = 300;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              in_valid = 1'b0;
  logic              in_stall;
  logic [1:0]        action = ACT_LIST;
  logic [5:0]        entry_id = '0;
  logic              auto_id = 1'b0;
  logic signed [7:0] pos_x = '0;
  logic signed [7:0] pos_y = '0;
  logic signed [7:0] pos_z = '0;
  logic              keep_id = 1'b0;
  logic              visible = 1'b0;
  logic              out_valid;
  logic              out_stall = 1'b1;
  logic [1:0]        status;
  logic [5:0]        result_id;
  logic              result_visible;
  logic              last;
  int                fail_count, pending_count, result_count;
  int                cycle_count = 0;
  bit                sending_done = 0;
  // Set by the stimulus to ask the receiver for one long hold; the receiver
  // counts the hold itself and clears the flag when it ends.
  bit                hold_results = 0;

  always #1 clk = ~clk;

  depth_ordered_entry_list dut (.*);

  depth_ordered_entry_list_checker chk (.*);

  // Watchdog. The limit covers every request walking the whole pool and
  // every result waiting out the longest stall, several times over.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  // Receiver: a fresh random wait before each result, with one long hold on
  // request. Stall is only ever changed once per edge.
  initial begin : receiver
    int gap;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (hold_results) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_results = 0;
      end else begin
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 19);
        if (gap > 0) begin
          out_stall <= 1'b1;
          repeat (gap) @(posedge clk);
        end
        out_stall <= 1'b0;
        @(posedge clk);
        while (!out_valid) @(posedge clk);
      end
    end
  end

  // Offers one request and waits until the block takes it. The random gap
  // goes before valid rises, so valid stays high between back-to-back ones.
  task automatic send_request(action_t a, int id, int au, int x, int y, int z,
                              int kp, int v, int quiet);
    int gap;
    gap = (quiet != 0) ? 0 : (($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 19));
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    action <= a; entry_id <= 6'(id); auto_id <= au[0];
    pos_x <= 8'(x); pos_y <= 8'(y); pos_z <= 8'(z); keep_id <= kp[0]; visible <= v[0];
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // Random request. Keys come from a narrow range most of the time so that
  // equal keys and ties on x or y are common; ids are kept small so removes
  // and updates find their entries.
  task automatic send_random(int quiet);
    action_t a;
    int x, y, z, id;
    int r;
    r = $urandom_range(0, 99);
    a = (r < 45) ? ACT_INSERT : (r < 70) ? ACT_REMOVE : (r < 88) ? ACT_SET_VIS : ACT_LIST;
    if ($urandom_range(0, 3) == 0) begin
      x = $urandom; y = $urandom; z = $urandom;
    end else begin
      x = $urandom_range(0, 3) - 2; y = $urandom_range(0, 3) - 2;
      z = $urandom_range(0, 4) - 2;
    end
    id = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 63) : $urandom_range(0, 15);
    send_request(a, id, $urandom_range(0, 2) != 0, x, y, z, $urandom_range(0, 1),
                 $urandom_range(0, 1), quiet);
  endtask

  initial begin : stimulus
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: the empty list on every action, then extremes of key and
    // id, a front insert, an equal key, a duplicate explicit id, an id kept
    // on remove, an absent id and a listing.
    send_request(ACT_LIST,    0, 0, 0, 0, 0, 0, 0, 0);
    send_request(ACT_REMOVE,  5, 0, 0, 0, 0, 0, 0, 0);
    send_request(ACT_SET_VIS, 5, 0, 0, 0, 0, 0, 1, 0);
    send_request(ACT_INSERT, 63, 0,  127, -128,  127, 0, 1, 0);
    send_request(ACT_INSERT,  0, 1, -128,  127, -128, 0, 0, 0);
    send_request(ACT_INSERT,  0, 1,    0,    0,   -1, 0, 1, 0);
    send_request(ACT_INSERT,  0, 1,    0,    0,    0, 0, 1, 0);
    send_request(ACT_INSERT, 63, 0,    0,    0,    0, 0, 0, 0);
    send_request(ACT_INSERT, 42, 0,    0,    5,    0, 1, 1, 0);
    send_request(ACT_LIST,    0, 0, 0, 0, 0, 0, 0, 0);
    send_request(ACT_SET_VIS, 63, 0, 0, 0, 0, 0, 0, 0);
    send_request(ACT_SET_VIS, 17, 0, 0, 0, 0, 0, 1, 0);
    send_request(ACT_REMOVE,  0, 0, 0, 0, 0, 1, 0, 0);
    send_request(ACT_REMOVE, 63, 0, 0, 0, 0, 0, 0, 0);
    send_request(ACT_REMOVE, 33, 0, 0, 0, 0, 0, 0, 0);
    send_request(ACT_INSERT,  0, 1, 1, 1, 1, 0, 0, 0);
    send_request(ACT_LIST,    0, 0, 0, 0, 0, 0, 0, 0);

    // Fill the pool with auto ids, then try once more on a full pool and
    // list all 64 entries. The receiver holds off meanwhile, so the block
    // backs up and stalls its input.
    hold_results = 1;
    for (int n = 0; n < 62; n++)
      send_request(ACT_INSERT, n, 1, $urandom, $urandom, $urandom, 0, n % 2, 1);
    send_request(ACT_INSERT, 0, 1, 0, 0, 0, 0, 0, 1);
    send_request(ACT_LIST, 0, 0, 0, 0, 0, 0, 0, 1);

    // Exhaust the id map while a slot is free: entries are removed with
    // keep set, so their ids stay taken and the last auto insert runs out.
    send_request(ACT_REMOVE, 5, 0, 0, 0, 0, 1, 0, 1);
    send_request(ACT_INSERT, 0, 1, 3, 3, 3, 0, 1, 1);
    send_request(ACT_REMOVE, 6, 0, 0, 0, 0, 1, 0, 1);
    send_request(ACT_INSERT, 0, 1, 3, 3, 3, 0, 1, 1);

    // Empty it again by id so the random phase starts from a small list;
    // ids held twice are removed once more.
    for (int n = 0; n < 64; n++)
      send_request(ACT_REMOVE, n, 0, 0, 0, 0, 0, 0, 1);
    send_request(ACT_REMOVE, 42, 0, 0, 0, 0, 0, 0, 1);
    send_request(ACT_REMOVE, 63, 0, 0, 0, 0, 0, 0, 1);

    for (int n = 0; n < RANDOM_REQUESTS; n++) send_random(n % 50 > 40);

    in_valid <= 1'b0;
    sending_done = 1;
  end

  initial begin : verdict
    wait (sending_done);
    while (pending_count != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    $display("Run covered directed corner requests, a full pool with a held receiver,");
    $display("and random requests; %0d results were checked.", result_count);
    if (fail_count == 0 && pending_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
